>>> hw/rtl/rxb_pkg.sv
// Package for the rectangle XOR light board: field widths, reset values,
// command and register codes, and the controller/datapath interface structs.
// No dependencies.
package rxb_pkg;

    // Default board size limits, handed to the top level parameters.
    localparam int unsigned DEF_MAX_ROWS = 16;
    localparam int unsigned DEF_MAX_COLS = 16;

    // Fixed field widths.
    localparam int unsigned COORD_W = 4;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned BITS_W  = 16;

    // Configuration register reset values.
    localparam logic [CFG_W-1:0] ROWS_RESET = 5'd10;
    localparam logic [CFG_W-1:0] COLS_RESET = 5'd15;

    // Command codes carried in the input tuser.
    localparam logic CMD_TOGGLE = 1'b0;
    localparam logic CMD_SHOW   = 1'b1;

    // Register indexes, taken from paddr bit 2.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_toggle;  // capture rectangle, start at its top row
        logic load_show;    // capture column mask, start at row zero
        logic tog_rd;       // read the current row for a toggle
        logic show_rd;      // read the current row for a display
        logic out_load;     // move the read row into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tog_empty;    // incoming rectangle toggles nothing
        logic show_empty;   // no rows in use
        logic row_at_end;   // row pointer sits on the final row
        logic rd_is_last;   // row in the read register is the final row
        logic out_free;     // output register can take a word this cycle
    } t_status;

endpackage

>>> hw/rtl/rectangle_xor_bitmap_board_unit.sv
// Top level of the rectangle XOR light board: configuration registers on the
// APB-style port, controller and datapath. Depends on rxb_pkg, rxb_ctrl, rxb_dp.
//
//   Channel   Dir  Handshake               Contents
//   s (in)    in   i_s_tvalid/o_s_tready   tdata: rectangle corners; tuser: command
//   m (out)   out  o_m_tvalid/i_m_tready   tdata: row index, row bits; tlast: last row
//   cfg       in   psel/penable/pready     rows_in_use at 0x0, cols_in_use at 0x4
//
// A toggle word is accepted, then the read/write-back row pipeline over the single row
// RAM handles one row per cycle over the clipped rectangle; the final row is written back in the drain state.
// A display word is read one row per cycle through the registered RAM read when the
// output is not stalled; an empty toggle is accepted without leaving the idle state.
// Reset is synchronous, active low; the board reads all dark right after reset.
// A stalled output holds the display pass; the next word is taken as soon as the
// final row sits in the output register.
module rectangle_xor_bitmap_board_unit
    import rxb_pkg::*;
#(
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // left_col[3:0], top_row[7:4], right_col[11:8],
                                     // bottom_row[15:12]
    input  logic        i_s_tuser,   // command[0]
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // row_index[3:0], row_bits[19:4], zero[23:20]
    output logic        o_m_tlast,   // last_row
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_W-1:0]  r_rows_in_use;
    logic [CFG_W-1:0]  r_cols_in_use;
    logic              cfg_wr;
    t_cmd              cmd;
    t_status           status;
    logic [IDX_W-1:0]  row_index;
    logic [BITS_W-1:0] row_bits;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RESET;
            r_cols_in_use <= COLS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROWS: r_rows_in_use <= pwdata[CFG_W-1:0];
                REG_COLS: r_cols_in_use <= pwdata[CFG_W-1:0];
                default:  r_rows_in_use <= r_rows_in_use;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = 32'(r_rows_in_use);
            REG_COLS: prdata = 32'(r_cols_in_use);
            default:  prdata = '0;
        endcase
    end

    rxb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rxb_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_tdata       (i_s_tdata),
        .i_rows_in_use (r_rows_in_use),
        .i_cols_in_use (r_cols_in_use),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_row_index   (row_index),
        .o_row_bits    (row_bits),
        .o_last_row    (o_m_tlast)
    );

    // Output word packing.
    assign o_m_tdata = {4'b0000, row_bits, row_index};

endmodule

>>> hw/rtl/rxb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rxb_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/rxb_dp.sv
// Datapath of the light board: rectangle decode, row RAM with valid bits,
// read-modify-write toggle pipeline and the output word register.
// Depends on rxb_pkg and rxb_ram.
module rxb_dp
    import rxb_pkg::*;
#(
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [4*COORD_W-1:0] i_tdata,
    input  logic [CFG_W-1:0]    i_rows_in_use,
    input  logic [CFG_W-1:0]    i_cols_in_use,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [IDX_W-1:0]    o_row_index,
    output logic [BITS_W-1:0]   o_row_bits,
    output logic                o_last_row
);

    localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [COORD_W-1:0]  left_col;
    logic [COORD_W-1:0]  top_row;
    logic [COORD_W-1:0]  right_col;
    logic [COORD_W-1:0]  bottom_row;
    logic [CFG_W-1:0]    nrows;
    logic [CFG_W-1:0]    ncols;
    logic [CFG_W-1:0]    nrows_m1;
    logic [CFG_W-1:0]    ncols_m1;
    logic [CFG_W-1:0]    right_c;
    logic [CFG_W-1:0]    bottom_c;
    logic [MAX_COLS-1:0] span;
    logic [MAX_COLS-1:0] colmask;

    logic [AW-1:0]       r_row;
    logic [AW-1:0]       r_last;
    logic [MAX_COLS-1:0] r_span;
    logic [MAX_COLS-1:0] r_colmask;
    logic [MAX_ROWS-1:0] r_valid;
    logic                r_wp;
    logic [AW-1:0]       r_rd_addr;
    logic                r_rd_valid;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_index;
    logic [BITS_W-1:0]   r_out_bits;
    logic                r_out_last;

    logic                rd_en;
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] rd_eff;
    logic                rd_is_last;

    // Input word fields.
    assign left_col   = i_tdata[COORD_W-1:0];
    assign top_row    = i_tdata[2*COORD_W-1:COORD_W];
    assign right_col  = i_tdata[3*COORD_W-1:2*COORD_W];
    assign bottom_row = i_tdata[4*COORD_W-1:3*COORD_W];

    // Board size in use, limited by the storage size.
    assign nrows = ({2'b00, i_rows_in_use} > 7'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : i_rows_in_use;
    assign ncols = ({2'b00, i_cols_in_use} > 7'(MAX_COLS)) ? CFG_W'(MAX_COLS) : i_cols_in_use;
    assign nrows_m1 = nrows - CFG_W'(1);
    assign ncols_m1 = ncols - CFG_W'(1);

    // Clip the far corner to the board in use.
    assign right_c  = ({1'b0, right_col} > ncols_m1) ? ncols_m1 : {1'b0, right_col};
    assign bottom_c = ({1'b0, bottom_row} > nrows_m1) ? nrows_m1 : {1'b0, bottom_row};

    // Column span of the rectangle and mask of the columns in use.
    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            span[j]    = (j >= left_col) && (j <= right_c);
            colmask[j] = (j < ncols);
        end
    end

    // Status toward the controller.
    assign rd_is_last = (r_rd_addr == r_last);
    always_comb begin
        o_status.tog_empty  = (nrows == '0) || (ncols == '0) ||
                              ({1'b0, left_col} > right_c) || ({1'b0, top_row} > bottom_c);
        o_status.show_empty = (nrows == '0);
        o_status.row_at_end = (r_row == r_last);
        o_status.rd_is_last = rd_is_last;
        o_status.out_free   = !r_out_valid || i_m_tready;
    end

    // Row pointer and captured operands.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_toggle) begin
            r_row  <= AW'(top_row);
            r_last <= AW'(bottom_c);
            r_span <= span;
        end else if (i_cmd.load_show) begin
            r_row     <= '0;
            r_last    <= AW'(nrows_m1);
            r_colmask <= colmask;
        end else if (rd_en) begin
            r_row <= r_row + AW'(1);
        end
    end

    // Row storage; a row never written reads as all lights off.
    assign rd_en  = i_cmd.tog_rd || i_cmd.show_rd;
    assign rd_eff = r_rd_valid ? rd_data : '0;

    rxb_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_wp),
        .i_wr_addr (r_rd_addr),
        .i_wr_data (rd_eff ^ r_span),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_row),
        .o_rd_data (rd_data)
    );

    // Read address tracking and the valid bit of the row being read.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_addr  <= r_row;
            r_rd_valid <= r_valid[r_row];
        end
    end

    // Write-back stage and per-row valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_valid <= '0;
        end else begin
            r_wp <= i_cmd.tog_rd;
            if (r_wp) begin
                r_valid[r_rd_addr] <= 1'b1;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= IDX_W'(r_rd_addr);
            r_out_bits  <= BITS_W'(rd_eff & r_colmask);
            r_out_last  <= rd_is_last;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_row_index = r_out_index;
    assign o_row_bits  = r_out_bits;
    assign o_last_row  = r_out_last;

`ifndef SYNTH
    // A write-back never hits the row being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp && rd_en) |-> (r_rd_addr != r_row))
        else $error("write-back and read address collide");

    // A new word is loaded only when the held one is gone or leaving.
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("output word overwritten before it was taken");

    // Reads stay within the captured row range.
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_row <= r_last))
        else $error("row read beyond final row");
`endif

endmodule

>>> hw/rtl/rxb_ctrl.sv
// Controller of the light board: accepts words, sequences the toggle and
// display row passes and paces display rows against the output register.
// Depends on rxb_pkg.
module rxb_ctrl
    import rxb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tuser,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_TOGGLE  = 5'b00010,
        ST_DRAIN   = 5'b00100,
        ST_SHOW_RD = 5'b01000,
        ST_SHOW_WT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_tuser == CMD_SHOW) begin
                        if (!i_status.show_empty) begin
                            o_cmd.load_show = 1'b1;
                            n_state         = ST_SHOW_RD;
                        end
                    end else if (!i_status.tog_empty) begin
                        o_cmd.load_toggle = 1'b1;
                        n_state           = ST_TOGGLE;
                    end
                end
            end
            ST_TOGGLE: begin
                o_cmd.tog_rd = 1'b1;
                if (i_status.row_at_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The final row is written back in this cycle.
                n_state = ST_IDLE;
            end
            ST_SHOW_RD: begin
                o_cmd.show_rd = 1'b1;
                n_state       = ST_SHOW_WT;
            end
            ST_SHOW_WT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.rd_is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.show_rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
